/* rtl/rwmf_pkg.sv */
// ----------------------------------------------------------------------------
// rwmf_pkg
// Constants, types and register codes shared by the RGB window median filter.
// ----------------------------------------------------------------------------
package rwmf_pkg;

    localparam int MAX_RADIUS     = 2;
    localparam int MAX_LINE_BYTES = 4096;
    localparam int COMPONENTS     = 3;
    localparam int MAX_FRAME_ROWS = 4096;

    localparam int WIN_SIDE = 2 * MAX_RADIUS + 1;
    localparam int WIN_N    = WIN_SIDE * WIN_SIDE;
    localparam int WIN_MID  = WIN_N / 2;
    localparam int TAP_LEN  = COMPONENTS * 2 * MAX_RADIUS + 1;
    localparam int LINES    = 2 * MAX_RADIUS;
    localparam int ADDR_W   = $clog2(MAX_LINE_BYTES);
    localparam int LAG_MAX  = MAX_RADIUS * MAX_LINE_BYTES + COMPONENTS * MAX_RADIUS;
    localparam int PEND_W   = $clog2(LAG_MAX + 2);

    localparam int RAD_W   = 2;
    localparam int LB_W    = 13;
    localparam int CNT_W   = 12;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [7:0] t_byte;
    typedef logic [WIN_N-1:0][7:0] t_win;
    typedef logic [LINES-1:0][7:0] t_line_word;

    typedef struct packed {
        logic  border;
        logic  last;
        t_byte center;
    } t_info;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_PAD   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_RADIUS_ROWS = 2'd0,
        REG_RADIUS_COLS = 2'd1,
        REG_LINE_BYTES  = 2'd2,
        REG_FRAME_ROWS  = 2'd3
    } t_reg_idx;

endpackage

/* rtl/rwmf_ram.sv */
// ----------------------------------------------------------------------------
// rwmf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rwmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rwmf_median.sv */
// ----------------------------------------------------------------------------
// rwmf_median
// Two-stage rank selector returning the middle element of a padded window.
// ----------------------------------------------------------------------------
module rwmf_median (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rwmf_pkg::t_win  i_win,
    input  rwmf_pkg::t_info i_info,
    output logic           o_valid,
    output rwmf_pkg::t_byte o_median,
    output rwmf_pkg::t_info o_info
);
    import rwmf_pkg::*;

    logic                  r_v1, r_v2;
    t_win                  r_win1, r_win2;
    t_info                 r_info1, r_info2;
    logic [WIN_N-1:0][WIN_N-1:0] r_lt;
    logic [WIN_N-1:0][WIN_N-1:0] w_lt;
    t_byte                 w_median;

    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            for (int j = 0; j < WIN_N; j++) begin
                w_lt[i][j] = (r_win1[j] < r_win1[i]) || ((r_win1[j] == r_win1[i]) && (j < i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_win1  <= i_win;
            r_info1 <= i_info;
            r_lt    <= w_lt;
            r_win2  <= r_win1;
            r_info2 <= r_info1;
        end
    end

    always_comb begin
        w_median = '0;
        for (int i = 0; i < WIN_N; i++) begin
            if ($countones(r_lt[i]) == WIN_MID) begin
                w_median = w_median | r_win2[i];
            end
        end
    end

    assign o_valid  = r_v2;
    assign o_median = w_median;
    assign o_info   = r_info2;

endmodule

/* rtl/rgb_window_median_filter.sv */
// ----------------------------------------------------------------------------
// rgb_window_median_filter
// Streaming median filter over interleaved three-component image bytes.
// ----------------------------------------------------------------------------
// Words enter on the input channel (i_in_valid/o_in_ready) in raster order,
// one component byte each, and leave on the output channel
// (o_out_valid/i_out_ready). An output word follows the input word that
// completes its window via the window, median and output registers; in
// words the stream lags by radius_rows lines plus three times radius_cols
// bytes. Pad words drain the frame once its last image byte is in, one
// output each, and o_frame_last marks the final output of the frame.
// Throughput is one word per cycle while the receiver does not stall and
// no internal shift runs, set by the read-modify-write of the line RAM,
// which is read one address ahead of its write. For a frame no longer than
// the lag, internal shift cycles with o_in_ready low follow the last image byte.
// Reset clears all counters and restores the register defaults; the line
// RAM holds no reset value and needs no clearing. When the receiver stalls
// the whole pipeline holds and o_in_ready falls with it.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module rgb_window_median_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  rwmf_pkg::t_byte               i_pixel_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rwmf_pkg::t_byte               o_filtered_byte,
    output logic                          o_frame_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rwmf_pkg::PADDR_W-1:0]  paddr,
    input  logic [rwmf_pkg::PDATA_W-1:0]  pwdata,
    output logic [rwmf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import rwmf_pkg::*;

    logic [RAD_W-1:0]  r_radius_rows, r_radius_cols;
    logic [LB_W-1:0]   r_line_bytes, r_frame_rows;
    logic [RAD_W-1:0]  w_rv, w_rh;
    logic [LB_W-1:0]   w_lb, w_rows;
    logic [PEND_W-1:0] w_lag, w_hb;

    logic [CNT_W-1:0]  r_in_col, r_in_row, r_out_col, r_out_row;
    logic [CNT_W-1:0]  n_in_col, n_in_row, n_out_col, n_out_row;
    logic [PEND_W-1:0] r_pending, n_pending, r_fill, n_fill;
    logic              r_in_done, n_in_done;

    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic              r_fwd, n_fwd;
    t_line_word        r_fwd_data, w_q_ram, w_q, w_wdata;

    t_byte             r_tap [WIN_SIDE][TAP_LEN];
    t_byte             w_row [WIN_SIDE];
    t_byte             w_x;

    logic              w_adv, w_acc, w_shift, w_emit, w_border, w_last;
    logic              r_s0_valid, r_s0_border, r_s0_last;
    t_win              w_win;
    t_info             w_info, w_med_info;
    logic              w_med_valid;
    t_byte             w_median;

    logic              r_out_valid, r_out_last;
    t_byte             r_out_byte;

    logic              w_cfg_we;
    t_reg_idx          w_idx;

    assign w_idx    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_we = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_comb begin
        unique case (w_idx)
            REG_RADIUS_ROWS: prdata = PDATA_W'(r_radius_rows);
            REG_RADIUS_COLS: prdata = PDATA_W'(r_radius_cols);
            REG_LINE_BYTES:  prdata = PDATA_W'(r_line_bytes);
            REG_FRAME_ROWS:  prdata = PDATA_W'(r_frame_rows);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_rows <= RAD_W'(1);
            r_radius_cols <= RAD_W'(1);
            r_line_bytes  <= LB_W'(4096);
            r_frame_rows  <= LB_W'(480);
        end else if (w_cfg_we) begin
            unique case (w_idx)
                REG_RADIUS_ROWS: r_radius_rows <= pwdata[RAD_W-1:0];
                REG_RADIUS_COLS: r_radius_cols <= pwdata[RAD_W-1:0];
                REG_LINE_BYTES:  r_line_bytes  <= pwdata[LB_W-1:0];
                REG_FRAME_ROWS:  r_frame_rows  <= pwdata[LB_W-1:0];
            endcase
        end
    end

    assign w_rv = (r_radius_rows > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_radius_rows;
    assign w_rh = (r_radius_cols > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_radius_cols;
    assign w_lb = (r_line_bytes == '0) ? LB_W'(1) :
                  (r_line_bytes > MAX_LINE_BYTES) ? LB_W'(MAX_LINE_BYTES) : r_line_bytes;
    assign w_rows = (r_frame_rows == '0) ? LB_W'(1) :
                    (r_frame_rows > MAX_FRAME_ROWS) ? LB_W'(MAX_FRAME_ROWS) : r_frame_rows;
    assign w_hb  = PEND_W'(COMPONENTS * w_rh);
    assign w_lag = PEND_W'(PEND_W'(w_rv) * PEND_W'(w_lb)) + w_hb;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv && (r_fill == '0);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pending = r_pending;
        n_in_done = r_in_done;
        n_fill    = r_fill;
        w_shift   = 1'b0;
        w_emit    = 1'b0;
        w_border  = 1'b0;
        w_last    = 1'b0;
        w_x       = i_pixel_byte;
        if (r_fill != '0) begin
            if (w_adv) begin
                w_shift = 1'b1;
                w_x     = '0;
                n_fill  = r_fill - PEND_W'(1);
                w_emit  = (r_fill == PEND_W'(1));
            end
        end else if (w_acc) begin
            if (r_in_done) begin
                w_shift = 1'b1;
                w_emit  = 1'b1;
            end else if (i_op == OP_PIXEL) begin
                w_shift   = 1'b1;
                n_pending = r_pending + PEND_W'(1);
                if ((LB_W'(r_in_col) + LB_W'(1)) >= w_lb) begin
                    n_in_col = '0;
                    if ((LB_W'(r_in_row) + LB_W'(1)) >= w_rows) begin
                        n_in_row  = '0;
                        n_in_done = 1'b1;
                    end else begin
                        n_in_row = r_in_row + CNT_W'(1);
                    end
                end else begin
                    n_in_col = r_in_col + CNT_W'(1);
                end
                if (n_pending > w_lag) begin
                    w_emit = 1'b1;
                end else if (n_in_done) begin
                    n_fill = w_lag - n_pending + PEND_W'(1);
                end
            end
        end
        if (w_emit) begin
            w_border = (r_out_row < CNT_W'(w_rv)) ||
                       ((LB_W'(r_out_row) + LB_W'(w_rv)) >= w_rows) ||
                       (PEND_W'(r_out_col) < w_hb) ||
                       ((PEND_W'(r_out_col) + w_hb) >= PEND_W'(w_lb));
            n_pending = n_pending - PEND_W'(1);
            if ((LB_W'(r_out_col) + LB_W'(1)) >= w_lb) begin
                n_out_col = '0;
                n_out_row = r_out_row + CNT_W'(1);
                w_last    = (LB_W'(r_out_row) + LB_W'(1)) >= w_rows;
            end else begin
                n_out_col = r_out_col + CNT_W'(1);
            end
            if (w_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_pending = '0;
                n_in_done = 1'b0;
            end
        end
    end

    always_comb begin
        if (w_cfg_we && (w_idx == REG_LINE_BYTES)) begin
            n_ptr = '0;
        end else if (w_shift && ((LB_W'(r_ptr) + LB_W'(1)) >= w_lb)) begin
            n_ptr = '0;
        end else if (w_shift) begin
            n_ptr = r_ptr + ADDR_W'(1);
        end else begin
            n_ptr = r_ptr;
        end
        n_fwd = w_shift && (n_ptr == r_ptr);
    end

    assign w_q = r_fwd ? r_fwd_data : w_q_ram;

    always_comb begin
        w_row[0] = w_x;
        for (int r = 1; r < WIN_SIDE; r++) begin
            w_row[r] = w_q[r-1];
        end
        for (int r = 0; r < LINES; r++) begin
            w_wdata[r] = w_row[r];
        end
    end

    rwmf_ram #(
        .WIDTH(LINES * 8),
        .DEPTH(MAX_LINE_BYTES)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (w_shift),
        .i_waddr(r_ptr),
        .i_wdata(w_wdata),
        .i_raddr(n_ptr),
        .o_rdata(w_q_ram)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_pending   <= '0;
            r_in_done   <= 1'b0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_fwd       <= 1'b0;
            r_s0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pending <= n_pending;
            r_in_done <= n_in_done;
            r_fill    <= n_fill;
            r_ptr     <= n_ptr;
            r_fwd     <= n_fwd;
            if (w_adv) begin
                r_s0_valid  <= w_emit;
                r_out_valid <= w_med_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= w_wdata;
        if (w_shift) begin
            for (int r = 0; r < WIN_SIDE; r++) begin
                r_tap[r][0] <= w_row[r];
                for (int k = 1; k < TAP_LEN; k++) begin
                    r_tap[r][k] <= r_tap[r][k-1];
                end
            end
        end
        if (w_adv) begin
            r_s0_border <= w_border;
            r_s0_last   <= w_last;
            r_out_byte  <= w_med_info.border ? w_med_info.center : w_median;
            r_out_last  <= w_med_info.last;
        end
    end

    // Unused window places are padded half with zero and half with full scale.
    always_comb begin
        for (int r = 0; r < WIN_SIDE; r++) begin
            for (int c = 0; c < WIN_SIDE; c++) begin
                if ((r <= 2 * int'(w_rv)) && (c <= 2 * int'(w_rh))) begin
                    w_win[r * WIN_SIDE + c] = r_tap[r][COMPONENTS * c];
                end else if (((r + c) % 2) == 1) begin
                    w_win[r * WIN_SIDE + c] = 8'hFF;
                end else begin
                    w_win[r * WIN_SIDE + c] = 8'h00;
                end
            end
        end
        w_info.border = r_s0_border;
        w_info.last   = r_s0_last;
        w_info.center = r_tap[w_rv][COMPONENTS * int'(w_rh)];
    end

    rwmf_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s0_valid),
        .i_win   (w_win),
        .i_info  (w_info),
        .o_valid (w_med_valid),
        .o_median(w_median),
        .o_info  (w_med_info)
    );

    assign o_out_valid     = r_out_valid;
    assign o_filtered_byte = r_out_byte;
    assign o_frame_last    = r_out_last;

    a_fill_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) |-> !o_in_ready)
        else $error("input accepted during internal shift cycles");

    a_fill_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) |-> r_in_done)
        else $error("internal shift cycles outside frame drain");

    a_ptr_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LB_W'(r_ptr) < w_lb)
        else $error("line pointer beyond line length");

    a_done_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_done |-> ((r_in_col == '0) && (r_in_row == '0)))
        else $error("input counters not wrapped at frame end");

    a_emit_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_valid && $past(w_adv)) |-> $past(w_shift))
        else $error("output word issued without a window shift");

endmodule

/* tb/sv/tb_rgb_window_median_filter.sv */
// ----------------------------------------------------------------------------
// tb_rgb_window_median_filter
// Self-checking bench for the streaming RGB window median filter.
// ----------------------------------------------------------------------------
// A short table of directed words and register writes comes first, then
// whole frames of random size, radius and content. Frames drain with pad
// and pixel words. A behavioural predictor keeps its own line history and
// frame counters. It queues the expected word for each input word that
// yields an output, and a monitor compares each output with that queue.
// Both channels idle at random, and registers change only between frames.
// ----------------------------------------------------------------------------
module tb_rgb_window_median_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import rwmf_pkg::*;

    localparam int HIST_DEPTH = 2 * MAX_RADIUS * MAX_LINE_BYTES + 2 * COMPONENTS * MAX_RADIUS + 1;
    localparam int RANDOM_WORDS = 1550;

    typedef struct packed {
        t_byte pix;
        logic  last;
    } t_out_word;

    typedef struct {
        bit       is_reg;
        t_reg_idx idx;
        int       val;
        t_op      op;
        t_byte    pix;
        bit       typed;
        t_byte    exp_pix;
        bit       exp_last;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_op = OP_PIXEL;
    t_byte               i_pixel_byte = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_byte               o_filtered_byte;
    logic                o_frame_last;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    rgb_window_median_filter uut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state.
    logic [RAD_W-1:0] rad_rows = 1, rad_cols = 1;
    logic [LB_W-1:0]  cfg_line = 4096, cfg_rows = 480;
    t_byte            hist [HIST_DEPTH];
    int unsigned      wr_pos = HIST_DEPTH - 1;
    int unsigned      in_col, in_row, out_col, out_row, backlog;
    bit               frame_done;

    t_out_word   median_q[$];
    int          errors = 0;
    int          words_in = 0, words_out = 0, frames = 0;
    bit          quiet = 0;

    function automatic int unsigned eff_rv();
        return rad_rows > MAX_RADIUS ? MAX_RADIUS : rad_rows;
    endfunction

    function automatic int unsigned eff_rh();
        return rad_cols > MAX_RADIUS ? MAX_RADIUS : rad_cols;
    endfunction

    function automatic int unsigned eff_line();
        if (cfg_line == 0) return 1;
        return cfg_line > MAX_LINE_BYTES ? MAX_LINE_BYTES : cfg_line;
    endfunction

    function automatic int unsigned eff_rows();
        if (cfg_rows == 0) return 1;
        return cfg_rows > MAX_FRAME_ROWS ? MAX_FRAME_ROWS : cfg_rows;
    endfunction

    function automatic t_byte hist_back(longint back);
        if (back < 0 || back >= HIST_DEPTH) return '0;
        return hist[(HIST_DEPTH + wr_pos - back) % HIST_DEPTH];
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        backlog = 0; frame_done = 0;
    endfunction

    function automatic t_out_word next_median();
        int unsigned rv = eff_rv(), rh = eff_rh(), lb = eff_line(), nr = eff_rows();
        int unsigned hb = COMPONENTS * rh;
        longint      centre = longint'(backlog) - 1;
        t_byte       win [WIN_N];
        t_byte       t;
        int          n = 0, b;
        t_out_word   w;
        if (out_row < rv || out_row + rv >= nr || out_col < hb || out_col + hb >= lb) begin
            w.pix = hist_back(centre);
        end else begin
            for (int k = -int'(rv); k <= int'(rv); k++)
                for (int j = -int'(rh); j <= int'(rh); j++) begin
                    win[n] = hist_back(centre - longint'(k) * lb - longint'(j) * COMPONENTS);
                    n++;
                end
            for (int a = 1; a < n; a++) begin
                t = win[a];
                b = a;
                while (b > 0 && win[b-1] > t) begin
                    win[b] = win[b-1];
                    b--;
                end
                win[b] = t;
            end
            w.pix = win[n/2];
        end
        backlog--;
        w.last = 1'b0;
        out_col++;
        if (out_col >= lb) begin
            out_col = 0;
            out_row++;
            if (out_row >= nr) w.last = 1'b1;
        end
        if (w.last) restart_frame();
        return w;
    endfunction

    function automatic bit predict_word(t_op op, t_byte pix, output t_out_word w);
        if (frame_done && backlog == 0) restart_frame();
        if (frame_done) begin
            w = next_median();
            return 1;
        end
        if (op == OP_PAD) return 0;
        wr_pos = (wr_pos + 1) % HIST_DEPTH;
        hist[wr_pos] = pix;
        backlog++;
        in_col++;
        if (in_col >= eff_line()) begin
            in_col = 0;
            in_row++;
            if (in_row >= eff_rows()) begin
                in_row = 0;
                frame_done = 1;
            end
        end
        if (backlog > eff_rv() * eff_line() + COMPONENTS * eff_rh() || frame_done) begin
            w = next_median();
            return 1;
        end
        return 0;
    endfunction

    task automatic report(string what, t_out_word want, t_out_word got);
        $display("MISMATCH %s: expected byte %02h last %0b, got byte %02h last %0b",
                 what, want.pix, want.last, got.pix, got.last);
        errors++;
    endtask

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver stalls.
    int stall = 0;
    always @(posedge i_clk) begin
        if (stall > 0) begin
            stall <= stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_out_word got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_filtered_byte, o_frame_last};
            words_out++;
            if (median_q.size() == 0) begin
                report("unexpected word", '0, got);
            end else if (got != median_q[0]) begin
                report("output word", median_q[0], got);
                void'(median_q.pop_front());
            end else begin
                void'(median_q.pop_front());
            end
        end
    end

    task automatic send_word(t_op op, t_byte pix, output bit got, output t_out_word w);
        int gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_pixel_byte <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        words_in++;
        got = predict_word(op, pix, w);
        if (got) median_q.push_back(w);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (median_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(idx));
        pwdata <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RADIUS_ROWS: rad_rows = RAD_W'(val);
            REG_RADIUS_COLS: rad_cols = RAD_W'(val);
            REG_LINE_BYTES:  cfg_line = LB_W'(val);
            default:         cfg_rows = LB_W'(val);
        endcase
    endtask

    task automatic run_frame(int rv, int rh, int lb, int nr);
        bit        got;
        t_out_word w;
        int        n;
        wait_idle();
        write_reg(REG_RADIUS_ROWS, rv);
        write_reg(REG_RADIUS_COLS, rh);
        write_reg(REG_LINE_BYTES, lb);
        write_reg(REG_FRAME_ROWS, nr);
        quiet = ($urandom_range(0, 5) == 0);
        n = eff_line() * eff_rows();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) send_word(OP_PAD, t_byte'($urandom), got, w);
            send_word(OP_PIXEL, t_byte'($urandom), got, w);
        end
        while (frame_done)
            send_word($urandom_range(0, 3) == 0 ? OP_PIXEL : OP_PAD, t_byte'($urandom), got, w);
        frames++;
    endtask

    t_row plan[] = '{
        '{1, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'h00, 0, 8'h00, 0},
        '{1, REG_RADIUS_COLS, 0, OP_PIXEL, 8'h00, 0, 8'h00, 0},
        '{1, REG_LINE_BYTES,  1, OP_PIXEL, 8'h00, 0, 8'h00, 0},
        '{1, REG_FRAME_ROWS,  3, OP_PIXEL, 8'h00, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PAD,   8'h5A, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'h00, 1, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'hFF, 1, 8'hFF, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'hA5, 1, 8'hA5, 1},
        '{1, REG_RADIUS_COLS, 1, OP_PIXEL, 8'h00, 0, 8'h00, 0},
        '{1, REG_LINE_BYTES,  7, OP_PIXEL, 8'h00, 0, 8'h00, 0},
        '{1, REG_FRAME_ROWS,  1, OP_PIXEL, 8'h00, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'h10, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'hF0, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'h30, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'h40, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'h01, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'hC3, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'h70, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PAD,   8'h00, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PIXEL, 8'hEE, 0, 8'h00, 0},
        '{0, REG_RADIUS_ROWS, 0, OP_PAD,   8'h00, 0, 8'h00, 0}
    };

    initial begin
        bit        got;
        t_out_word w;
        int        start_words;
        restart_frame();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_reg) begin
                wait_idle();
                write_reg(plan[r].idx, plan[r].val);
            end else begin
                send_word(plan[r].op, plan[r].pix, got, w);
                if (plan[r].typed && (!got || w != '{plan[r].exp_pix, plan[r].exp_last}))
                    report("pass-through word", '{plan[r].exp_pix, plan[r].exp_last}, w);
            end
        end

        start_words = words_in;
        while (words_in - start_words < RANDOM_WORDS)
            run_frame($urandom_range(0, 3), $urandom_range(0, 3),
                      $urandom_range(0, 24), $urandom_range(0, 8));
        run_frame(3, 3, 14, 6);
        run_frame(2, 2, 13, 5);

        wait_idle();
        $display("Covered %0d input words and %0d output words over %0d frames.",
                 words_in, words_out, frames);
        if (errors == 0) begin
            $display("tb_rgb_window_median_filter passed");
        end else begin
            $display("tb_rgb_window_median_filter failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("tb_rgb_window_median_filter failed");
        $finish;
    end

endmodule
